### rtl/sfd_pkg.sv
// Shared types, constants and the CRC-16/MODBUS bit step for the serial frame deframer.
// No dependencies. Every rtl file imports this package.
package sfd_pkg;

  localparam int FRAME_BYTES_DEF = 32;
  localparam int BYTE_W          = 8;
  localparam int IDX_W           = 6;
  localparam int TDATA_IN_W      = 8;
  localparam int TDATA_OUT_W     = 16;
  localparam int PADDR_W         = 4;
  localparam int PDATA_W         = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
  localparam logic [7:0] HEADER_SECOND_RST = 8'd85;
  localparam logic [7:0] FOOTER_VALUE_RST  = 8'd13;

  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_FOOTER_VALUE  = 2'd2;
  localparam logic [1:0] REG_COUNT         = 2'd3;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] footer_value;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_msg_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c);
    logic [15:0] r;
    r = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return r;
  endfunction

endpackage

### rtl/sfd_front.sv
// Front end: header hunt, frame collection, bit-serial CRC and frame check.
// Writes payload bytes into the back end's frame store. Depends on sfd_pkg.
module sfd_front
  import sfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_IN_W-1:0] s_tdata,   // [7:0] rx_byte
  output bank_msg_t             push,
  input  bank_msg_t             rel,
  output logic                  mem_we,
  output logic [((FRAME_BYTES > 6) ? $clog2(FRAME_BYTES - 5) : 1):0] mem_waddr,
  output logic [BYTE_W-1:0]     mem_wdata
);

  localparam int PLEN  = FRAME_BYTES - 5;
  localparam int IW    = (PLEN > 1) ? $clog2(PLEN) : 1;
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  localparam logic [CNT_W-1:0] POS_FIRST_PL = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_PL_END   = CNT_W'(FRAME_BYTES - 4);
  localparam logic [CNT_W-1:0] POS_CRC_LO   = CNT_W'(FRAME_BYTES - 3);
  localparam logic [CNT_W-1:0] POS_CRC_HI   = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] POS_FOOTER   = CNT_W'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {HUNT1, HUNT2, FILL} phase_t;

  phase_t           phase;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       hdr0;
  logic [7:0]       hdr1;
  logic [7:0]       crc_lo;
  logic [7:0]       crc_hi;
  logic [15:0]      crc;
  logic [2:0]       bits_left;
  logic             wbank;
  logic [1:0]       busy;
  logic [1:0]       busy_next;

  logic       accept;
  logic [7:0] b;
  logic       frame_ok;
  logic       in_payload;

  assign b          = s_tdata[7:0];
  assign s_tready   = (bits_left == 3'd0) && !busy[wbank];
  assign accept     = s_tvalid && s_tready;
  assign in_payload = (phase == FILL) && (cnt <= POS_PL_END);
  assign frame_ok   = (hdr0 == cfg.header_first) && (hdr1 == cfg.header_second) &&
                      (b == cfg.footer_value) && (crc == {crc_hi, crc_lo});

  assign mem_we     = accept && in_payload;
  assign mem_waddr  = {wbank, IW'(cnt - POS_FIRST_PL)};
  assign mem_wdata  = b;

  assign push.valid = accept && (phase == FILL) && (cnt == POS_FOOTER) && frame_ok;
  assign push.bank  = wbank;

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (push.valid) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= HUNT1;
      cnt       <= '0;
      bits_left <= 3'd0;
      wbank     <= 1'b0;
      busy      <= 2'b00;
    end else begin
      if (bits_left != 3'd0) begin
        crc       <= crc_step(crc);
        bits_left <= bits_left - 3'd1;
      end
      busy <= busy_next;
      if (accept) begin
        case (phase)
          HUNT1: begin
            if (b == cfg.header_first) begin
              hdr0  <= b;
              cnt   <= CNT_W'(1);
              phase <= HUNT2;
            end
          end
          HUNT2: begin
            if (b == cfg.header_second) begin
              hdr1  <= b;
              cnt   <= CNT_W'(2);
              crc   <= CRC_INIT;
              phase <= FILL;
            end else if (b == cfg.header_first) begin
              hdr0  <= b;
              cnt   <= CNT_W'(1);
              phase <= HUNT2;
            end else begin
              cnt   <= '0;
              phase <= HUNT1;
            end
          end
          FILL: begin
            if (cnt <= POS_PL_END) begin
              crc       <= crc_step(crc ^ {8'h00, b});
              bits_left <= 3'd7;
            end
            if (cnt == POS_CRC_LO) begin
              crc_lo <= b;
            end
            if (cnt == POS_CRC_HI) begin
              crc_hi <= b;
            end
            if (cnt == POS_FOOTER) begin
              cnt   <= '0;
              phase <= HUNT1;
              if (frame_ok) begin
                wbank <= ~wbank;
              end
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
          end
          default: begin
            cnt   <= '0;
            phase <= HUNT1;
          end
        endcase
      end
    end
  end

endmodule

### rtl/sfd_queue.sv
// Two-entry queue of validated frame banks between front and back end.
// Depends on sfd_pkg.
module sfd_queue
  import sfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bank_msg_t push,
  input  logic      pop,
  output logic      q_valid,
  output logic      q_bank
);

  logic       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign q_valid = (count != 2'd0);
  assign q_bank  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push.valid) begin
        slot[wp] <= push.bank;
        wp       <= ~wp;
      end
      if (pop && q_valid) begin
        rp <= ~rp;
      end
      case ({push.valid, pop && q_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/sfd_back.sv
// Back end: two-bank frame store and payload emission through an output register.
// Depends on sfd_pkg.
module sfd_back
  import sfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic                   q_bank,
  output logic                   q_pop,
  input  logic                   mem_we,
  input  logic [((FRAME_BYTES > 6) ? $clog2(FRAME_BYTES - 5) : 1):0] mem_waddr,
  input  logic [BYTE_W-1:0]      mem_wdata,
  output bank_msg_t              rel,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [7:0] payload_byte, [13:8] payload_index
  output logic                   m_tlast    // payload_last
);

  localparam int PLEN = FRAME_BYTES - 5;
  localparam int IW   = (PLEN > 1) ? $clog2(PLEN) : 1;
  localparam int AW   = IW + 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(PLEN - 1);

  typedef enum logic [1:0] {IDLE, READ, SHOW} state_t;

  logic [BYTE_W-1:0] mem [2**AW];
  logic [BYTE_W-1:0] rdata;
  state_t            state;
  logic              bank;
  logic [IW-1:0]     idx;
  logic              last_r;

  assign q_pop     = (state == IDLE) && q_valid;
  assign rel.valid = (state == SHOW) && m_tready && last_r;
  assign rel.bank  = bank;
  assign m_tdata   = {{(TDATA_OUT_W - BYTE_W - IDX_W){1'b0}}, IDX_W'(idx), rdata};
  assign m_tlast   = last_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == READ) begin
      rdata <= mem[{bank, idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (q_valid) begin
            bank  <= q_bank;
            idx   <= '0;
            state <= READ;
          end
        end
        READ: begin
          last_r   <= (idx == IDX_LAST);
          m_tvalid <= 1'b1;
          state    <= SHOW;
        end
        SHOW: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (last_r) begin
              state <= IDLE;
            end else begin
              idx   <= idx + IW'(1);
              state <= READ;
            end
          end
        end
        default: begin
          m_tvalid <= 1'b0;
          state    <= IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/serial_frame_deframer_crc16_core.sv
// Top level of the serial frame deframer with CRC-16/MODBUS check.
// Holds the register file and APB port; instantiates sfd_front, sfd_queue, sfd_back.
//
// Usage:
//   s_t* carries received bytes (s_tdata[7:0]). The block hunts for the two
//   header bytes, collects FRAME_BYTES bytes, and at the footer byte checks
//   header, footer and the little-endian CRC-16/MODBUS over the payload.
//   A good frame leaves m_t* as FRAME_BYTES-5 items (payload byte, index,
//   tlast on the final one); a bad frame is dropped.
//   After each payload byte s_tready stays low while the CRC update runs,
//   one bit per cycle; header, CRC and footer bytes add no such wait.
//   Each output item is a registered frame-store read, then the output
//   register, which holds it until taken; only then is the next byte read.
//   A good frame is queued at its footer byte, emitted once the back end is idle.
//   Two frame banks: the front collects the next frame while the back emits
//   the previous one. With both banks waiting on a stalled receiver,
//   s_tready drops until a bank is released.
//   Reset: hunt for a header; registers return to 0xAA, 0x55, 0x0D.
//   The frame store needs no clearing pass.
//   Registers: 0x0 header_first, 0x4 header_second, 0x8 footer_value.
module serial_frame_deframer_crc16_core
  import sfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] rx_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [7:0] payload_byte, [13:8] payload_index
  output logic                   m_tlast,   // payload_last
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  localparam int PLEN = FRAME_BYTES - 5;
  localparam int IW   = (PLEN > 1) ? $clog2(PLEN) : 1;

  cfg_t       cfg;
  logic       cfg_we;
  logic [1:0] reg_sel;

  bank_msg_t  push;
  bank_msg_t  rel;
  logic       q_valid;
  logic       q_bank;
  logic       q_pop;
  logic       mem_we;
  logic [IW:0]       mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= HEADER_FIRST_RST;
      cfg.header_second <= HEADER_SECOND_RST;
      cfg.footer_value  <= FOOTER_VALUE_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_HEADER_FIRST:  cfg.header_first  <= pwdata[7:0];
        REG_HEADER_SECOND: cfg.header_second <= pwdata[7:0];
        REG_FOOTER_VALUE:  cfg.footer_value  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HEADER_FIRST:  prdata = {24'h0, cfg.header_first};
      REG_HEADER_SECOND: prdata = {24'h0, cfg.header_second};
      REG_FOOTER_VALUE:  prdata = {24'h0, cfg.footer_value};
      default:           prdata = '0;
    endcase
  end

  sfd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .rel       (rel),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  sfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_bank  (q_bank)
  );

  sfd_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_bank    (q_bank),
    .q_pop     (q_pop),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .rel       (rel),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

### rtl/sfd_checker.sv
// Port-level checks for the serial frame deframer, bound to the top level.
// Depends on sfd_pkg and serial_frame_deframer_crc16_core.
module sfd_checker
  import sfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [TDATA_OUT_W-1:0] m_tdata,
  input logic                   m_tlast,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [PADDR_W-1:0]     paddr,
  input logic [PDATA_W-1:0]     pwdata,
  input logic [PDATA_W-1:0]     prdata
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 6);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[13:8] == IDX_LAST)))
    else $error("tlast does not match final payload index");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(psel && penable && pwrite && (paddr[3:2] != REG_COUNT)) &&
    (paddr[3:2] == $past(paddr[3:2])) |-> prdata[7:0] == $past(pwdata[7:0]))
    else $error("register readback differs from last write");

endmodule

bind serial_frame_deframer_crc16_core sfd_checker #(.FRAME_BYTES(FRAME_BYTES)) u_sfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

### dv/serial_frame_deframer_crc16_core_tb.sv
// Self-checking testbench for serial_frame_deframer_crc16_core: random framed byte streams
// with random stream stalls, APB register changes between phases, scoreboard prediction.
// Depends on sfd_pkg and the rtl top level only.
module serial_frame_deframer_crc16_core_tb;
  import sfd_pkg::*;

  localparam int FRAME_LEN      = FRAME_BYTES_DEF;
  localparam int PAYLOAD_LEN    = FRAME_LEN - 5;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RX_HOLD_CYCLES = 900;
  localparam int PHASE_ITEMS    = 1;
  localparam int CYCLE_LIMIT    = 300000;

  typedef enum logic [1:0] {
    HUNT_FIRST  = 2'd0,
    HUNT_SECOND = 2'd1,
    COLLECT     = 2'd2
  } parse_phase_e;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_FOOTER, FR_BAD_SECOND, FR_NOISE} frame_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic [5:0] index;
    logic       last;
  } payload_item_t;

  class frame_checker;
    logic [7:0]    hdr_first;
    logic [7:0]    hdr_second;
    logic [7:0]    footer;
    parse_phase_e  phase;
    logic [6:0]    fill;
    logic [7:0]    store [FRAME_LEN];
    payload_item_t payload_due[$];
    int            errors;
    int            checked;
    int            frames_passed;
    int            frames_dropped;

    function new();
      hdr_first  = HEADER_FIRST_RST;
      hdr_second = HEADER_SECOND_RST;
      footer     = FOOTER_VALUE_RST;
      phase      = HUNT_FIRST;
      fill       = '0;
      errors     = 0;
      checked    = 0;
      frames_passed  = 0;
      frames_dropped = 0;
    endfunction

    static function logic [15:0] crc16(input logic [7:0] bytes[$]);
      logic [15:0] c;
      c = CRC_INIT;
      foreach (bytes[i]) begin
        c = c ^ {8'h00, bytes[i]};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        REG_HEADER_FIRST:  hdr_first = v;
        REG_HEADER_SECOND: hdr_second = v;
        REG_FOOTER_VALUE:  footer = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_HEADER_FIRST:  return hdr_first;
        REG_HEADER_SECOND: return hdr_second;
        default:           return footer;
      endcase
    endfunction

    function void close_frame();
      logic [7:0]    pay[$];
      logic [15:0]   sent_crc;
      payload_item_t it;
      pay = {};
      for (int i = 2; i < FRAME_LEN - 3; i++) pay.push_back(store[i]);
      sent_crc = {store[FRAME_LEN-2], store[FRAME_LEN-3]};
      if (store[0] != hdr_first || store[1] != hdr_second ||
          store[FRAME_LEN-1] != footer || crc16(pay) != sent_crc) begin
        frames_dropped++;
        return;
      end
      frames_passed++;
      foreach (pay[i]) begin
        it.data  = pay[i];
        it.index = 6'(i);
        it.last  = (i == PAYLOAD_LEN - 1);
        payload_due.push_back(it);
      end
    endfunction

    function void take_rx_byte(logic [7:0] b);
      case (phase)
        HUNT_FIRST: begin
          if (b == hdr_first) begin
            store[0] = b;
            fill = 7'd1;
            phase = HUNT_SECOND;
          end
        end
        HUNT_SECOND: begin
          if (b == hdr_second) begin
            store[1] = b;
            fill = 7'd2;
            phase = COLLECT;
          end else if (b == hdr_first) begin
            store[0] = b;
            fill = 7'd1;
            phase = HUNT_SECOND;
          end else begin
            fill = '0;
            phase = HUNT_FIRST;
          end
        end
        COLLECT: begin
          store[fill] = b;
          fill = fill + 7'd1;
          if (fill >= FRAME_LEN) begin
            close_frame();
            fill = '0;
            phase = HUNT_FIRST;
          end
        end
        default: begin
          fill = '0;
          phase = HUNT_FIRST;
        end
      endcase
    endfunction

    function void check_payload(logic [7:0] d, logic [5:0] ix, logic last);
      payload_item_t e;
      if (payload_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected payload item: expected none, actual byte %02h index %0d",
                 $time, d, ix);
        return;
      end
      e = payload_due.pop_front();
      checked++;
      if (d !== e.data) begin
        errors++;
        $display("%0t: payload_byte expected %02h actual %02h", $time, e.data, d);
      end
      if (ix !== e.index) begin
        errors++;
        $display("%0t: payload_index expected %0d actual %0d", $time, e.index, ix);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: payload_last expected %0b actual %0b", $time, e.last, last);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata;   // [7:0] rx_byte
  logic                   m_tvalid;
  logic                   m_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;   // [7:0] payload_byte, [13:8] payload_index
  logic                   m_tlast;   // payload_last
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  frame_checker sb = new();
  int  bytes_sent  = 0;
  int  cycle_count = 0;
  bit  tx_calm     = 1'b0;
  bit  rx_calm     = 1'b0;
  bit  rx_hold_req = 1'b0;

  serial_frame_deframer_crc16_core #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) sb.check_payload(m_tdata[7:0], m_tdata[13:8], m_tlast);
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d payload items outstanding", $time, sb.payload_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : rx_side
    int n;
    m_tready <= 1'b0;
    wait (!rst);
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        n = pick_gap(rx_calm);
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int n;
    n = pick_gap(tx_calm);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.take_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  function automatic void build_frame(input frame_kind_e kind, output logic [7:0] q[$]);
    logic [7:0]  pay[$];
    logic [15:0] crc;
    logic [7:0]  pick [3];
    int          mode;
    q = {};
    pay = {};
    pick[0] = sb.hdr_first;
    pick[1] = sb.hdr_second;
    pick[2] = sb.footer;
    case (kind)
      FR_NOISE: begin
        repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
        return;
      end
      FR_BAD_SECOND: begin
        q.push_back(sb.hdr_first);
        q.push_back($urandom_range(0, 1) ? sb.hdr_first
                                         : sb.hdr_second ^ 8'($urandom_range(1, 255)));
        return;
      end
      default: ;
    endcase
    mode = $urandom_range(0, 9);
    repeat (PAYLOAD_LEN) begin
      case (mode)
        6:       pay.push_back(8'h00);
        7:       pay.push_back(8'hFF);
        8:       pay.push_back(pick[$urandom_range(0, 2)]);
        default: pay.push_back(8'($urandom));
      endcase
    end
    crc = frame_checker::crc16(pay);
    if (kind == FR_BAD_CRC) crc ^= 16'($urandom_range(1, 65535));
    q.push_back(sb.hdr_first);
    q.push_back(sb.hdr_second);
    q = {q, pay};
    q.push_back(crc[7:0]);
    q.push_back(crc[15:8]);
    q.push_back(kind == FR_BAD_FOOTER ? sb.footer ^ 8'($urandom_range(1, 255)) : sb.footer);
  endfunction

  task automatic send_frame(input frame_kind_e kind);
    logic [7:0] q[$];
    build_frame(kind, q);
    send_bytes(q);
  endtask

  task automatic send_random_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62)      send_frame(FR_GOOD);
    else if (r < 72) send_frame(FR_BAD_CRC);
    else if (r < 80) send_frame(FR_BAD_FOOTER);
    else if (r < 90) send_frame(FR_BAD_SECOND);
    else             send_frame(FR_NOISE);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.payload_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic apb_read(input logic [1:0] idx, output logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic verify_regs();
    logic [1:0]         regs [3] = '{REG_HEADER_FIRST, REG_HEADER_SECOND, REG_FOOTER_VALUE};
    logic [PDATA_W-1:0] got;
    foreach (regs[i]) begin
      apb_read(regs[i], got);
      if (got[7:0] !== sb.reg_value(regs[i])) begin
        sb.errors++;
        $display("%0t: register %0d readback expected %02h actual %02h",
                 $time, regs[i], sb.reg_value(regs[i]), got[7:0]);
      end
    end
  endtask

  task automatic program_regs(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] ft);
    apb_write(REG_HEADER_FIRST, h1);
    apb_write(REG_HEADER_SECOND, h2);
    apb_write(REG_FOOTER_VALUE, ft);
    verify_regs();
  endtask

  initial begin : stimulus
    logic [7:0] hunt_cases[$];
    logic [7:0] q[$];
    int         target;
    hunt_cases = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'hAA, 8'h13, 8'hAA, 8'hAA};
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    verify_regs();
    // hunt: noise, lone second header, bad second, repeated first header
    send_bytes(hunt_cases);
    send_frame(FR_GOOD);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1: program_regs(8'h00, 8'hFF, 8'hFF);
          2: program_regs(8'hFF, 8'h00, 8'h00);
          3: program_regs(8'($urandom), 8'($urandom), 8'($urandom));
          default: program_regs(8'h7E, 8'h7E, 8'($urandom));
        endcase
      end
      if (ph == 1) begin
        // stall the receiver while three frames stream in back to back
        tx_calm = 1'b1;
        rx_hold_req = 1'b1;
        repeat (3) send_frame(FR_GOOD);
        tx_calm = 1'b0;
      end
      if (ph == 2) begin
        // change registers with a frame partly collected
        build_frame(FR_GOOD, q);
        send_bytes(q[0:11]);
        wait_drained();
        apb_write(REG_COUNT, 8'($urandom));
        apb_write(REG_HEADER_SECOND, 8'($urandom));
        verify_regs();
        send_bytes(q[12:$]);
      end
      rx_calm = (ph == 3);
      tx_calm = (ph == 3);
      target = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < target ||
             (ph == 4 && sb.checked + sb.payload_due.size() < 60))
        send_random_unit();
      tx_calm = 1'b0;
      rx_calm = 1'b0;
    end

    wait_drained();
    $display("%0d bytes sent under 5 register settings, %0d frames passed, %0d dropped",
             bytes_sent, sb.frames_passed, sb.frames_dropped);
    $display("%0d payload items checked, receiver stall and mid-frame register change done",
             sb.checked);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sfd_pkg.sv
rtl/sfd_front.sv
rtl/sfd_queue.sv
rtl/sfd_back.sv
rtl/serial_frame_deframer_crc16_core.sv
rtl/sfd_checker.sv
dv/serial_frame_deframer_crc16_core_tb.sv
